// ===== rtl/b64e_pkg.sv =====
// types, constants and the base64 alphabet shared by the encoder modules
package b64e_pkg;

  localparam logic [7:0] PadChar = 8'h3D;
  localparam logic [1:0] LastIdx = 2'd3;

  localparam logic [1:0] FullGroup = 2'd3;
  localparam logic [1:0] TwoBytes  = 2'd2;
  localparam logic [1:0] OneByte   = 2'd1;

  // one group of up to three bytes waiting to be turned into four characters
  typedef struct packed {
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
    logic [1:0] nbytes;
    logic       fin;
  } b64e_group_t;

  function automatic logic [7:0] b64e_sextet_char(logic [5:0] sextet);
    logic [7:0] ext;
    logic [7:0] ch;
    ext = {2'b00, sextet};
    if (sextet < 6'd26) begin
      ch = 8'h41 + ext;
    end else if (sextet < 6'd52) begin
      ch = 8'h47 + ext;
    end else if (sextet < 6'd62) begin
      ch = ext - 8'd4;
    end else if (sextet == 6'd62) begin
      ch = 8'h2B;
    end else begin
      ch = 8'h2F;
    end
    return ch;
  endfunction

endpackage

// ===== rtl/base64_stream_encoder.sv =====
// top level of the streaming base64 encoder
//
// channel  dir  tdata          tlast      tuser
// s_axis   in   in_byte[7:0]   is_final   -
// m_axis   out  out_char[7:0]  run_end    stream_end
//
// one byte accepted per cycle while the group queue has room
// every third byte, and every final byte, yields four characters, sent one per cycle
// while m_axis is ready, so the character serializer sets the pace,
// the more so when every byte is final
// reset clears pending bytes, queue and serializer at once, no sweep
// a stalled m_axis holds the serializer; the queue then fills and drops s_axis_tready
module base64_stream_encoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast,
  output logic       m_axis_tuser    // [0] stream_end
);
  import b64e_pkg::*;

  localparam int unsigned LvlW = $clog2(QueueDepth + 1);

  b64e_group_t     push_grp;
  b64e_group_t     head_grp;
  logic            push;
  logic            full;
  logic            head_valid;
  logic            pop;
  logic [LvlW-1:0] level;

  b64e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_byte_i    (s_axis_tdata),
    .in_final_i   (s_axis_tlast),
    .in_ready_o   (s_axis_tready),
    .push_o       (push),
    .group_o      (push_grp),
    .queue_full_i (full)
  );

  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_grp),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .pop_data_o  (head_grp),
    .level_o     (level)
  );

  b64e_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .grp_valid_i  (head_valid),
    .grp_i        (head_grp),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_char_o   (m_axis_tdata),
    .run_end_o    (m_axis_tlast),
    .stream_end_o (m_axis_tuser)
  );

  // stream end only on the last character of a group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("stream end without run end");

  // a final byte always closes a group into the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |-> push)
    else $error("final byte did not issue a group");

  // queue never overflows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= LvlW'(QueueDepth))
    else $error("group queue overflow");

  // no request taken while the queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !s_axis_tready)
    else $error("input taken with full queue");

endmodule

// ===== rtl/b64e_front.sv =====
// front end: collects bytes into groups of three and issues finished groups
module b64e_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          in_byte_i,
  input  logic                in_final_i,
  output logic                in_ready_o,
  output logic                push_o,
  output b64e_pkg::b64e_group_t group_o,
  input  logic                queue_full_i
);
  import b64e_pkg::*;

  logic [7:0] first_q, first_d;
  logic [7:0] second_q, second_d;
  logic [1:0] cnt_q, cnt_d;
  logic       accept;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && (cnt_q[1] || in_final_i);

  always_comb begin
    group_o.fin = in_final_i;
    if (cnt_q[1]) begin
      group_o.byte_a = first_q;
      group_o.byte_b = second_q;
      group_o.byte_c = in_byte_i;
      group_o.nbytes = FullGroup;
    end else if (cnt_q[0]) begin
      group_o.byte_a = first_q;
      group_o.byte_b = in_byte_i;
      group_o.byte_c = 8'h00;
      group_o.nbytes = TwoBytes;
    end else begin
      group_o.byte_a = in_byte_i;
      group_o.byte_b = 8'h00;
      group_o.byte_c = 8'h00;
      group_o.nbytes = OneByte;
    end
  end

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    cnt_d    = cnt_q;
    if (accept) begin
      if (push_o) begin
        first_d  = 8'h00;
        second_d = 8'h00;
        cnt_d    = 2'd0;
      end else if (cnt_q[0]) begin
        second_d = in_byte_i;
        cnt_d    = 2'd2;
      end else begin
        first_d  = in_byte_i;
        cnt_d    = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= 8'h00;
      second_q <= 8'h00;
      cnt_q    <= 2'd0;
    end else begin
      first_q  <= first_d;
      second_q <= second_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== rtl/b64e_queue.sv =====
// small register queue of byte groups between front end and serializer
module b64e_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  b64e_pkg::b64e_group_t push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output b64e_pkg::b64e_group_t pop_data_o,
  output logic [$clog2(Depth+1)-1:0] level_o
);
  import b64e_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64e_group_t       mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];
  assign level_o    = cnt_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/b64e_back.sv =====
// back end: holds one group, sends its four chars one per ready cycle
module b64e_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  grp_valid_i,
  input  b64e_pkg::b64e_group_t grp_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_char_o,
  output logic                  run_end_o,
  output logic                  stream_end_o
);
  import b64e_pkg::*;

  b64e_group_t grp_q, grp_d;
  logic        busy_q, busy_d;
  logic [1:0]  idx_q, idx_d;
  logic        send;
  logic        last;
  logic [5:0]  sextet;
  logic        pad;

  assign out_valid_o = busy_q;
  assign send        = busy_q && out_ready_i;
  assign last        = (idx_q == LastIdx);
  assign pop_o       = grp_valid_i && (!busy_q || (send && last));

  always_comb begin
    sextet = grp_q.byte_c[5:0];
    pad    = 1'b0;
    unique case (idx_q)
      2'd0: sextet = grp_q.byte_a[7:2];
      2'd1: sextet = {grp_q.byte_a[1:0], grp_q.byte_b[7:4]};
      2'd2: begin
        sextet = {grp_q.byte_b[3:0], grp_q.byte_c[7:6]};
        pad    = (grp_q.nbytes == OneByte);
      end
      default: begin
        sextet = grp_q.byte_c[5:0];
        pad    = (grp_q.nbytes != FullGroup);
      end
    endcase
  end

  assign out_char_o   = pad ? PadChar : b64e_sextet_char(sextet);
  assign run_end_o    = last;
  assign stream_end_o = last && grp_q.fin;

  always_comb begin
    grp_d  = grp_q;
    busy_d = busy_q;
    idx_d  = idx_q;
    if (send) begin
      idx_d = idx_q + 2'd1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
    if (pop_o) begin
      grp_d  = grp_i;
      busy_d = 1'b1;
      idx_d  = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

endmodule

// ===== verif/base64_stream_encoder_tb.sv =====
// testbench for base64_stream_encoder: directed groups and random messages vs a predictor
`timescale 1ns / 100ps

module base64_stream_encoder_tb;
  import b64e_pkg::*;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned TailCycles = 24;
  localparam int unsigned PhaseBytes = 43;
  localparam int unsigned NumDirected = 21;
  localparam logic [8*64-1:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] ch;
    logic       run_end;
    logic       stream_end;
  } b64_char_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        fin;
    logic        typed;
    logic [31:0] text;
  } stim_row_t;

  // data, final, typed, expected characters
  localparam stim_row_t Directed [NumDirected] = '{
    {8'h00, 1'b1, 1'b1, "AA=="},
    {8'hFF, 1'b1, 1'b1, "/w=="},
    {8'h00, 1'b0, 1'b0, 32'h0},
    {8'h00, 1'b1, 1'b1, "AAA="},
    {8'hFF, 1'b0, 1'b0, 32'h0},
    {8'hFF, 1'b1, 1'b1, "//8="},
    {8'h00, 1'b0, 1'b0, 32'h0},
    {8'h00, 1'b0, 1'b0, 32'h0},
    {8'h00, 1'b0, 1'b1, "AAAA"},
    {8'hFF, 1'b0, 1'b0, 32'h0},
    {8'hFF, 1'b0, 1'b0, 32'h0},
    {8'hFF, 1'b1, 1'b1, "////"},
    {8'h4D, 1'b0, 1'b0, 32'h0},
    {8'h61, 1'b0, 1'b0, 32'h0},
    {8'h6E, 1'b0, 1'b1, "TWFu"},
    {8'h4D, 1'b0, 1'b0, 32'h0},
    {8'h61, 1'b1, 1'b1, "TWE="},
    {8'h4D, 1'b1, 1'b1, "TQ=="},
    {8'hFB, 1'b0, 1'b0, 32'h0},
    {8'hFF, 1'b0, 1'b0, 32'h0},
    {8'hBF, 1'b1, 1'b0, 32'h0}
  };

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       m_axis_tuser;

  b64_char_t   char_q[$];
  logic [7:0]  pend_a = 8'h00;
  logic [7:0]  pend_b = 8'h00;
  logic [1:0]  pend_cnt = 2'd0;
  int unsigned send_idle_pct = 6;
  int unsigned recv_stall_pct = 61;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count = 0;
  int unsigned bytes_in = 0;
  int unsigned chars_out = 0;
  int unsigned msg_count = 0;

  base64_stream_encoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] sextet_ascii(input logic [5:0] s);
    return Alphabet[8*(63 - int'(s)) +: 8];
  endfunction

  task automatic queue_group(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                             input int unsigned nbytes, input logic fin,
                             input logic typed, input logic [31:0] text);
    logic [7:0] chars [4];
    b64_char_t  item;
    chars[0] = sextet_ascii(a[7:2]);
    chars[1] = sextet_ascii({a[1:0], b[7:4]});
    chars[2] = (nbytes < 2) ? PadChar : sextet_ascii({b[3:0], c[7:6]});
    chars[3] = (nbytes < 3) ? PadChar : sextet_ascii(c[5:0]);
    for (int k = 0; k < 4; k++) begin
      item.ch = typed ? text[8*(3-k) +: 8] : chars[k];
      item.run_end = (k == 3);
      item.stream_end = (k == 3) && fin;
      char_q.push_back(item);
    end
  endtask

  task automatic encode_request(input logic [7:0] data, input logic fin,
                                input logic typed, input logic [31:0] text);
    if (pend_cnt == 2'd2) begin
      queue_group(pend_a, pend_b, data, 3, fin, typed, text);
      pend_cnt = 2'd0;
    end else if (fin) begin
      if (pend_cnt == 2'd1) begin
        queue_group(pend_a, data, 8'h00, 2, 1'b1, typed, text);
      end else begin
        queue_group(data, 8'h00, 8'h00, 1, 1'b1, typed, text);
      end
      pend_cnt = 2'd0;
    end else if (pend_cnt == 2'd0) begin
      pend_a = data;
      pend_cnt = 2'd1;
    end else begin
      pend_b = data;
      pend_cnt = 2'd2;
    end
    if (pend_cnt == 2'd0) begin
      pend_a = 8'h00;
      pend_b = 8'h00;
    end
    if (fin) begin
      msg_count++;
    end
  endtask

  task automatic send_request(input logic [7:0] data, input logic fin,
                              input logic typed, input logic [31:0] text);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tlast <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_in++;
    encode_request(data, fin, typed, text);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (char_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_messages(input int unsigned count);
    int unsigned sent;
    int unsigned len;
    logic [7:0]  data;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 8);
      if (len > count - sent) len = count - sent;
      for (int unsigned k = 0; k < len; k++) begin
        if ($urandom_range(9) == 0) begin
          data = $urandom_range(1) ? 8'hFF : 8'h00;
        end else begin
          data = 8'($urandom);
        end
        send_request(data, k == len - 1, 1'b0, 32'h0);
      end
      sent += len;
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    b64_char_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      chars_out++;
      if (char_q.size() == 0) begin
        $error("unexpected character out_char=%h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = char_q.pop_front();
        if (m_axis_tdata !== want.ch) begin
          $error("out_char expected %h actual %h", want.ch, m_axis_tdata);
          mismatch_count++;
        end
        if (m_axis_tlast !== want.run_end) begin
          $error("run_end expected %b actual %b", want.run_end, m_axis_tlast);
          mismatch_count++;
        end
        if (m_axis_tuser !== want.stream_end) begin
          $error("stream_end expected %b actual %b", want.stream_end, m_axis_tuser);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("base64_stream_encoder_tb failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      send_request(Directed[i].data, Directed[i].fin, Directed[i].typed, Directed[i].text);
    end
    random_messages(PhaseBytes);
    drain_results();

    send_idle_pct = 61;
    recv_stall_pct = 6;
    random_messages(PhaseBytes);
    drain_results();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_messages(PhaseBytes);
    drain_results();
    repeat (TailCycles) @(posedge clk_i);

    $display("encoded %0d bytes in %0d messages into %0d characters, %0d mismatches",
             bytes_in, msg_count, chars_out, mismatch_count);
    $display("idling covered sender-light, receiver-light and back-to-back traffic");
    if (mismatch_count == 0 && char_q.size() == 0) begin
      $display("base64_stream_encoder_tb passed");
    end else begin
      $display("base64_stream_encoder_tb failed");
    end
    $finish;
  end

endmodule
